// ----- design/hsl_to_rgb_converter_core_defines.svh -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core_defines
// assertion macros shared by the converter rtl
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HSL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/hsl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// shared widths, constants and sector codes of the hsl to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

    localparam int HUE_W  = 16;
    localparam int Q_W    = 17;
    localparam int CH_W   = 8;
    localparam int H6_W   = HUE_W + 3;
    localparam int AS_W   = 33;
    localparam int NUM_W  = 50;
    localparam int SCL_W  = NUM_W + CH_W;
    localparam int CH_LSB = 49;

    localparam logic [Q_W-1:0]   ONE_Q16   = 17'd65536;
    localparam logic [Q_W:0]     ONE_Q16_W = 18'd65536;

    // hue sector, sixths of a turn
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

endpackage

`default_nettype wire

// ----- design/hsl_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// five-stage pipelined hsl to rgb pixel converter
// ----------------------------------------------------------------------------
// usage:
//   a pixel (i_hue, i_saturation, i_lightness) is taken at a rising edge with
//   start high and busy low. busy is never raised: one pixel per clock.
//   each result (o_red, o_green, o_blue, o_invalid) appears for one cycle
//   with o_valid high, in order, once its transfer has passed every stage.
//   stages: sector, fraction and lightness term; a*s multiply; (a*s)*t
//   multiply with offset and chroma sums; channel select; scale by 255.
//   throughput is one pixel per cycle; each of the two multiplies takes
//   a stage of its own.
//   saturation or lightness above 1.0 gives zero channels with o_invalid.
//   reset (synchronous, active low) clears the valid bits; pixels in flight
//   are dropped. the receiver cannot stall, results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_converter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hsl2rgb_pkg::HUE_W-1:0] i_hue,
    input  wire logic [hsl2rgb_pkg::Q_W-1:0]   i_saturation,
    input  wire logic [hsl2rgb_pkg::Q_W-1:0]   i_lightness,
    output logic                               o_valid,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_red,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_green,
    output logic      [hsl2rgb_pkg::CH_W-1:0]  o_blue,
    output logic                               o_invalid
);

    localparam int QW = hsl2rgb_pkg::Q_W;
    localparam int NW = hsl2rgb_pkg::NUM_W;
    localparam int AW = hsl2rgb_pkg::AS_W;

    // stage 1
    logic [hsl2rgb_pkg::H6_W-1:0] h6;
    logic [QW-1:0]                frac_w;
    logic [QW:0]                  lit2;
    logic [QW:0]                  dev;
    logic                         r1_v, r1_inv;
    logic                         n1_inv;
    hsl2rgb_pkg::t_sector         r1_sec, n1_sec;
    logic [QW-1:0]                r1_t, n1_t;
    logic [QW-1:0]                r1_a, n1_a;
    logic [QW-1:0]                r1_sat, r1_lit;

    // stage 2
    logic [2*QW-1:0]              prod_as;
    logic                         r2_v, r2_inv;
    hsl2rgb_pkg::t_sector         r2_sec;
    logic [QW-1:0]                r2_t, r2_lit;
    logic [AW-1:0]                r2_as, n2_as;

    // stage 3
    logic                         r3_v, r3_inv;
    hsl2rgb_pkg::t_sector         r3_sec;
    logic [NW-1:0]                r3_ast, n3_ast;
    logic [NW-1:0]                r3_mm, n3_mm;
    logic [NW-1:0]                r3_cm, n3_cm;

    // stage 4
    logic [NW-1:0]                xm;
    logic                         r4_v, r4_inv;
    logic [NW-1:0]                r4_r, r4_g, r4_b;
    logic [NW-1:0]                n4_r, n4_g, n4_b;

    // stage 5
    logic                         r5_v, r5_inv;

    logic                         take;

    assign busy = 1'b0;
    assign take = start && !busy;

    // ---- stage 1: sector, fraction, lightness term
    assign h6     = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
    assign frac_w = {1'b0, h6[hsl2rgb_pkg::HUE_W-1:0]};
    assign n1_sec = hsl2rgb_pkg::t_sector'(h6[hsl2rgb_pkg::H6_W-1:hsl2rgb_pkg::HUE_W]);
    assign n1_t   = h6[hsl2rgb_pkg::HUE_W] ? (hsl2rgb_pkg::ONE_Q16 - frac_w) : frac_w;
    assign lit2   = {i_lightness, 1'b0};
    assign dev    = (lit2 >= hsl2rgb_pkg::ONE_Q16_W) ? (lit2 - hsl2rgb_pkg::ONE_Q16_W)
                                                     : (hsl2rgb_pkg::ONE_Q16_W - lit2);
    assign n1_a   = QW'(hsl2rgb_pkg::ONE_Q16_W - dev);
    assign n1_inv = (i_saturation > hsl2rgb_pkg::ONE_Q16)
                 || (i_lightness > hsl2rgb_pkg::ONE_Q16);

    // ---- stage 2: a * s
    assign prod_as = r1_a * r1_sat;
    assign n2_as   = prod_as[AW-1:0];

    // ---- stage 3: (a*s) * t, offset and chroma sums
    assign n3_ast = r2_as * r2_t;
    assign n3_mm  = {r2_lit, 33'd0} - {1'b0, r2_as, 16'd0};
    assign n3_cm  = {r2_lit, 33'd0} + {1'b0, r2_as, 16'd0};

    // ---- stage 4: second component and channel order
    assign xm = r3_mm + {r3_ast[NW-2:0], 1'b0};

    always_comb begin
        case (r3_sec)
            hsl2rgb_pkg::SEC_R_TO_Y: begin
                n4_r = r3_cm; n4_g = xm;    n4_b = r3_mm;
            end
            hsl2rgb_pkg::SEC_Y_TO_G: begin
                n4_r = xm;    n4_g = r3_cm; n4_b = r3_mm;
            end
            hsl2rgb_pkg::SEC_G_TO_C: begin
                n4_r = r3_mm; n4_g = r3_cm; n4_b = xm;
            end
            hsl2rgb_pkg::SEC_C_TO_B: begin
                n4_r = r3_mm; n4_g = xm;    n4_b = r3_cm;
            end
            hsl2rgb_pkg::SEC_B_TO_M: begin
                n4_r = xm;    n4_g = r3_mm; n4_b = r3_cm;
            end
            default: begin
                n4_r = r3_cm; n4_g = r3_mm; n4_b = xm;
            end
        endcase
    end

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= take;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        r1_inv <= n1_inv;
        r1_sec <= n1_sec;
        r1_t   <= n1_t;
        r1_a   <= n1_a;
        r1_sat <= i_saturation;
        r1_lit <= i_lightness;

        r2_inv <= r1_inv;
        r2_sec <= r1_sec;
        r2_t   <= r1_t;
        r2_lit <= r1_lit;
        r2_as  <= n2_as;

        r3_inv <= r2_inv;
        r3_sec <= r2_sec;
        r3_ast <= n3_ast;
        r3_mm  <= n3_mm;
        r3_cm  <= n3_cm;

        r4_inv <= r3_inv;
        r4_r   <= n4_r;
        r4_g   <= n4_g;
        r4_b   <= n4_b;

        r5_inv <= r4_inv;
    end

    // ---- stage 5: scale by 255
    hsl2rgb_chan u_chan_r (
        .i_clk  (i_clk),
        .i_num  (r4_r),
        .i_clr  (r4_inv),
        .o_chan (o_red)
    );

    hsl2rgb_chan u_chan_g (
        .i_clk  (i_clk),
        .i_num  (r4_g),
        .i_clr  (r4_inv),
        .o_chan (o_green)
    );

    hsl2rgb_chan u_chan_b (
        .i_clk  (i_clk),
        .i_num  (r4_b),
        .i_clr  (r4_inv),
        .o_chan (o_blue)
    );

    assign o_valid   = r5_v;
    assign o_invalid = r5_inv;

    // ---- assertions
`include "hsl_to_rgb_converter_core_defines.svh"

    `HSL_ASSERT_NEXT(a_latency, take, ##4 o_valid, "transfer did not produce a result")
    `HSL_ASSERT_IMPL(a_no_phantom, o_valid, $past(take, 5), "result without a transfer")
    `HSL_ASSERT_IMPL(a_inv_track, o_valid, o_invalid == $past(n1_inv, 5), "invalid flag lost")
    `HSL_ASSERT_IMPL(a_gray, o_valid && $past(i_saturation == '0, 5) && !o_invalid,
        (o_red == o_green) && (o_green == o_blue), "zero saturation not gray")

endmodule

`default_nettype wire

// ----- design/hsl2rgb_chan.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_chan
// scales one channel numerator by 255 and keeps the integer part, or zero when cleared, registered
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_chan (
    input  wire logic                           i_clk,
    input  wire logic [hsl2rgb_pkg::NUM_W-1:0]  i_num,
    input  wire logic                           i_clr,
    output logic      [hsl2rgb_pkg::CH_W-1:0]   o_chan
);

    logic [hsl2rgb_pkg::SCL_W-1:0] scaled;
    logic [hsl2rgb_pkg::CH_W-1:0]  r_chan;
    logic [hsl2rgb_pkg::CH_W-1:0]  n_chan;

    // num * 255 as (num << 8) - num
    assign scaled = {i_num, {hsl2rgb_pkg::CH_W{1'b0}}}
                  - {{hsl2rgb_pkg::CH_W{1'b0}}, i_num};

    assign n_chan = i_clr ? '0
                  : scaled[hsl2rgb_pkg::CH_LSB +: hsl2rgb_pkg::CH_W];

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire
